/* rtl/core/tapid_pkg.sv */
package tapid_pkg;

	localparam int GAIN_W = 16;
	localparam int BAND_W = 16;
	localparam int ONE_Q = 4096;
	localparam int SUM_W = 64;

	// Register indexes
	localparam logic [2:0] REG_GOAL = 3'd0;
	localparam logic [2:0] REG_GAINS_X = 3'd1;
	localparam logic [2:0] REG_GAINS_Y = 3'd2;
	localparam logic [2:0] REG_GAINS_Z = 3'd3;
	localparam logic [2:0] REG_HYST_X = 3'd4;
	localparam logic [2:0] REG_HYST_Y = 3'd5;
	localparam logic [2:0] REG_HYST_Z = 3'd6;

	// Reset values
	localparam logic [47:0] GOAL_RST = 48'd214761472;
	localparam logic [47:0] GAINS_XY_RST = 48'd119627724098970;
	localparam logic [47:0] GAINS_Z_RST = 48'd133702331927347;
	localparam logic [31:0] HYST_X_RST = 32'd80544154;
	localparam logic [14:0] HYST_Y_RST = 15'd410;
	localparam logic [31:0] HYST_Z_RST = 32'd32243917;

	// Top-level sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_MERGE,
		ST_OUT
	} state_t;

	// Phases inside one lane
	typedef enum logic [2:0] {
		LN_IDLE,
		LN_DIV,
		LN_MUL,
		LN_SUM,
		LN_ROUND
	} lane_st_t;

	// Controls from top level to each lane
	typedef struct packed {
		logic start;
		logic clear_integ;
	} lane_ctl_t;

endpackage

/* rtl/core/tapid_div.sv */
// Restoring divider, one quotient bit per cycle, truncates toward zero
module tapid_div #(
	parameter int NUM_W = 18,
	parameter int DEN_W = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [DEN_W-1:0] den,
	output logic                    done,
	output logic signed [NUM_W-1:0] quo
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] mag_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [CW-1:0]    cnt_q;
	logic             neg_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;

	assign trial = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : num;
			neg_q <= num[NUM_W-1];
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= CW'(NUM_W);
		end else if (busy_q) begin
			mag_q <= {mag_q[NUM_W-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
			if (trial >= {1'b0, den}) begin
				rem_q <= trial - {1'b0, den};
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? NUM_W'(-quo_q) : quo_q;
endmodule

/* rtl/core/tapid_lane.sv */
// One axis: error, trapezoid integral, derivative, weighted sum
module tapid_lane #(
	parameter int DATA_WIDTH = 16,
	parameter int ACC_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tapid_pkg::lane_ctl_t         ctl,
	input  logic signed [DATA_WIDTH-1:0] goal,
	input  logic signed [DATA_WIDTH-1:0] meas,
	input  logic        [15:0]           dt,
	input  logic        [47:0]           gains,
	output logic signed [DATA_WIDTH:0]   err,
	output logic signed [63:0]           drive,
	output logic                         done
);
	import tapid_pkg::*;

	localparam int EW = DATA_WIDTH + 1;
	localparam int DW = DATA_WIDTH + 2;
	localparam int PW = DW + 17;
	localparam int NW = ((PW > ACC_WIDTH) ? PW : ACC_WIDTH) + 1;

	lane_st_t                    ln_q, ln_d;
	logic                        step_div, step_mul, step_sum, step_rnd;
	logic signed [EW-1:0]        prev_q;
	logic signed [ACC_WIDTH-1:0] integ_q;
	logic signed [EW-1:0]        err_s1;
	logic signed [DW-1:0]        dquo;
	logic                        ddone;
	logic signed [PW-1:0]        prod;
	logic signed [PW-1:0]        half;
	logic signed [NW-1:0]        nsum;
	logic signed [ACC_WIDTH-1:0] ni;
	logic signed [ACC_WIDTH-1:0] ni_s2;
	logic signed [DW-1:0]        deriv_s2;
	logic signed [EW+16:0]       pp;
	logic signed [DW+16:0]       dp;
	logic signed [ACC_WIDTH+16:0] ip;
	logic signed [SUM_W-1:0]     p_s3, d_s3, i_s3;
	logic signed [SUM_W-1:0]     s_s4;
	logic signed [SUM_W:0]       pd, tot;
	logic signed [SUM_W-1:0]     s;
	logic signed [SUM_W-1:0]     q;
	localparam logic signed [SUM_W-1:0] LIM = 64'sh4000_0000_0000_0000;
	localparam logic signed [ACC_WIDTH:0] AMAX = (ACC_WIDTH+1)'((65'sd1 <<< (ACC_WIDTH-1)) - 1);
	localparam logic signed [ACC_WIDTH:0] AMIN = -(ACC_WIDTH+1)'(65'sd1 <<< (ACC_WIDTH-1));

	assign err = err_s1;

	tapid_div #(.NUM_W(DW), .DEN_W(16)) u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.start && dt != 16'd0),
		.num(DW'(goal) - DW'(meas) - DW'(prev_q)), .den(dt),
		.done(ddone), .quo(dquo)
	);

	// Trapezoid step with floor on halving, saturating integral
	assign prod = (PW'(err_s1) + PW'(prev_q)) * $signed({1'b0, dt});
	assign half = prod >>> 1;
	assign nsum = NW'(integ_q) + NW'(half);
	always_comb begin
		if (nsum > NW'(AMAX)) ni = AMAX[ACC_WIDTH-1:0];
		else if (nsum < NW'(AMIN)) ni = AMIN[ACC_WIDTH-1:0];
		else ni = ACC_WIDTH'(nsum);
	end

	// Gain products at their exact widths
	assign pp = err_s1 * $signed({1'b0, gains[15:0]});
	assign dp = deriv_s2 * $signed({1'b0, gains[47:32]});
	assign ip = ni_s2 * $signed({1'b0, gains[31:16]});

	// Sum with 64-bit saturation, limit and round
	assign pd = (SUM_W+1)'(p_s3) + (SUM_W+1)'(d_s3);
	assign tot = (SUM_W+1)'(s_s4) + (SUM_W+1)'(i_s3);
	always_comb begin
		if (tot > (SUM_W+1)'(64'sh7FFF_FFFF_FFFF_FFFF)) s = 64'sh7FFF_FFFF_FFFF_FFFF;
		else if (tot < -(SUM_W+1)'(65'sh0_8000_0000_0000_0000)) s = 64'sh8000_0000_0000_0000;
		else s = SUM_W'(tot);
		if (s > LIM) s = LIM;
		if (s < -LIM) s = -LIM;
		q = s + SUM_W'(ONE_Q / 2);
	end

	// Phase sequence: next state
	always_comb begin
		ln_d = ln_q;
		if (ctl.start) begin
			ln_d = LN_DIV;
		end else begin
			unique case (ln_q)
				LN_IDLE: ln_d = LN_IDLE;
				LN_DIV: if (dt == 16'd0 || ddone) ln_d = LN_MUL;
				LN_MUL: ln_d = LN_SUM;
				LN_SUM: ln_d = LN_ROUND;
				LN_ROUND: ln_d = LN_IDLE;
				default: ln_d = LN_IDLE;
			endcase
		end
	end

	// Phase sequence: step enables
	always_comb begin
		step_div = !ctl.start && ln_q == LN_DIV && (dt == 16'd0 || ddone);
		step_mul = ln_q == LN_MUL;
		step_sum = ln_q == LN_SUM;
		step_rnd = !ctl.start && ln_q == LN_ROUND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ln_q <= LN_IDLE;
			prev_q <= '0;
			integ_q <= '0;
			done <= 1'b0;
		end else begin
			ln_q <= ln_d;
			done <= step_rnd;
			if (ctl.clear_integ) integ_q <= '0;
			if (step_div) begin
				integ_q <= ni;
				prev_q <= err_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) err_s1 <= EW'(goal) - EW'(meas);
		if (step_div) begin
			ni_s2 <= ni;
			deriv_s2 <= (dt == 16'd0) ? '0 : dquo;
		end
		if (step_mul) begin
			p_s3 <= SUM_W'(pp);
			d_s3 <= SUM_W'(dp);
			i_s3 <= SUM_W'(ip);
		end
		if (step_sum) s_s4 <= SUM_W'(pd);
		if (step_rnd) drive <= q >>> 12;
	end
endmodule

/* rtl/core/tapid_merge.sv */
// Hysteresis hold, clamp and clip flags over the three lane results
module tapid_merge #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic signed [DATA_WIDTH:0] ex, ey, ez,
	input  logic signed [63:0]         dx, dy, dz,
	input  logic [31:0]                hyst_x,
	input  logic [14:0]                hyst_y,
	input  logic [31:0]                hyst_z,
	output logic signed [13:0]         roll,
	output logic signed [13:0]         pitch,
	output logic signed [14:0]         gaz,
	output logic                       roll_clipped,
	output logic                       pitch_clipped,
	output logic                       hold_xy_out,
	output logic                       hold_z_out
);
	import tapid_pkg::*;

	localparam int MW = DATA_WIDTH + 2;
	logic          hxy_q, hz_q, nxy, nz;
	logic [MW-1:0] ax, ay, az;
	logic signed [63:0] vx, vy, vz;

	assign ax = ex[DATA_WIDTH] ? MW'(-ex) : MW'(ex);
	assign ay = ey[DATA_WIDTH] ? MW'(-ey) : MW'(ey);
	assign az = ez[DATA_WIDTH] ? MW'(-ez) : MW'(ez);

	always_comb begin
		nxy = hxy_q;
		if (ax < MW'(hyst_x[15:0]) && ay < MW'(hyst_y)) nxy = 1'b1;
		else if (ax > MW'(hyst_x[31:16])) nxy = 1'b0;
		nz = hz_q;
		if (az < MW'(hyst_z[15:0])) nz = 1'b1;
		else if (az > MW'(hyst_z[31:16])) nz = 1'b0;
		vx = nxy ? '0 : dx;
		vy = nxy ? '0 : dy;
		vz = nz ? '0 : dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hxy_q <= 1'b0;
			hz_q <= 1'b0;
		end else if (en) begin
			hxy_q <= nxy;
			hz_q <= nz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_clipped <= vx > 64'sd4096 || vx < -64'sd4096;
			pitch_clipped <= vy > 64'sd4096 || vy < -64'sd4096;
			roll <= vx > 64'sd4096 ? 14'sd4096 : vx < -64'sd4096 ? -14'sd4096 : 14'(vx);
			pitch <= vy > 64'sd4096 ? 14'sd4096 : vy < -64'sd4096 ? -14'sd4096 : 14'(vy);
			gaz <= vz > 64'sd8192 ? 15'sd8192 : vz < -64'sd4096 ? -15'sd4096 : 15'(vz);
			hold_xy_out <= nxy;
			hold_z_out <= nz;
		end
	end
endmodule

/* rtl/core/three_axis_pid_with_deadband.sv */
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_stall | meas_x, meas_y, meas_z, tick_time
// out     | output    | out_valid/out_stall | roll, pitch, gaz, flags
// cfg     | APB       | psel/penable      | registers at 8*i, 64-bit data
// A result's timing is set by the 18-step serial divider in each lane when tick_time is
// nonzero; with zero tick_time the divider is skipped.
// Three lanes run in parallel, then the merge register and the ST_MERGE sequencer state follow.
// Reset clears integrals, previous errors, holds and registers to defaults.
// Input stalls from acceptance until the result is taken; out_stall lengthens that.
module three_axis_pid_with_deadband #(
	parameter int DATA_WIDTH = 16,
	parameter int ACC_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] meas_x,
	input  logic signed [DATA_WIDTH-1:0] meas_y,
	input  logic signed [DATA_WIDTH-1:0] meas_z,
	input  logic [15:0]                  tick_time,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [13:0]           roll,
	output logic signed [13:0]           pitch,
	output logic signed [14:0]           gaz,
	output logic                         roll_clipped,
	output logic                         pitch_clipped,
	output logic                         hold_xy_out,
	output logic                         hold_z_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [5:0]                   paddr,
	input  logic [63:0]                  pwdata,
	output logic [63:0]                  prdata,
	output logic                         pready
);
	import tapid_pkg::*;

	state_t st_q, st_d;
	logic [47:0] goal_q, gx_q, gy_q, gz_q;
	logic [31:0] hx_q, hz_q;
	logic [14:0] hy_q;
	logic [15:0] dt_q;
	logic signed [DATA_WIDTH-1:0] mx_q, my_q, mz_q;
	logic signed [DATA_WIDTH-1:0] glx, gly, glz;
	logic signed [DATA_WIDTH:0] ex, ey, ez;
	logic signed [63:0] dx, dy, dz;
	logic doe_x, doe_y, doe_z, wr, accept, merge_en;
	lane_ctl_t ctl;
	logic [2:0] idx;
	logic [127:0] goal_ext;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[5:3];
	assign accept = in_valid && !in_stall;
	// Goal lanes are DATA_WIDTH wide; bits past the register read zero
	assign goal_ext = {80'd0, goal_q};
	assign glx = goal_ext[DATA_WIDTH-1:0];
	assign gly = goal_ext[2*DATA_WIDTH-1 -: DATA_WIDTH];
	assign glz = goal_ext[3*DATA_WIDTH-1 -: DATA_WIDTH];

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q <= GOAL_RST;
			gx_q <= GAINS_XY_RST;
			gy_q <= GAINS_XY_RST;
			gz_q <= GAINS_Z_RST;
			hx_q <= HYST_X_RST;
			hy_q <= HYST_Y_RST;
			hz_q <= HYST_Z_RST;
		end else if (wr) begin
			unique case (idx)
				REG_GOAL: goal_q <= pwdata[47:0];
				REG_GAINS_X: gx_q <= pwdata[47:0];
				REG_GAINS_Y: gy_q <= pwdata[47:0];
				REG_GAINS_Z: gz_q <= pwdata[47:0];
				REG_HYST_X: hx_q <= pwdata[31:0];
				REG_HYST_Y: hy_q <= pwdata[14:0];
				REG_HYST_Z: hz_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GOAL: prdata = {16'd0, goal_q};
			REG_GAINS_X: prdata = {16'd0, gx_q};
			REG_GAINS_Y: prdata = {16'd0, gy_q};
			REG_GAINS_Z: prdata = {16'd0, gz_q};
			REG_HYST_X: prdata = {32'd0, hx_q};
			REG_HYST_Y: prdata = {49'd0, hy_q};
			REG_HYST_Z: prdata = {32'd0, hz_q};
			default: prdata = '0;
		endcase
	end

	// Sequencer
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (accept) st_d = ST_DIV;
			ST_DIV: if (doe_x) st_d = ST_MERGE;
			ST_MERGE: st_d = ST_OUT;
			ST_OUT: if (!out_stall) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = st_q != ST_IDLE;
		out_valid = st_q == ST_OUT;
		merge_en = st_q == ST_DIV && doe_x;
		ctl.start = accept;
		ctl.clear_integ = wr && idx == REG_GOAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mx_q <= meas_x;
			my_q <= meas_y;
			mz_q <= meas_z;
			dt_q <= tick_time;
		end
	end

	tapid_lane #(.DATA_WIDTH(DATA_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_lx (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .goal(glx), .meas(accept ? meas_x : mx_q),
		.dt(accept ? tick_time : dt_q), .gains(gx_q), .err(ex), .drive(dx), .done(doe_x));
	tapid_lane #(.DATA_WIDTH(DATA_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_ly (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .goal(gly), .meas(accept ? meas_y : my_q),
		.dt(accept ? tick_time : dt_q), .gains(gy_q), .err(ey), .drive(dy), .done(doe_y));
	tapid_lane #(.DATA_WIDTH(DATA_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_lz (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .goal(glz), .meas(accept ? meas_z : mz_q),
		.dt(accept ? tick_time : dt_q), .gains(gz_q), .err(ez), .drive(dz), .done(doe_z));

	tapid_merge #(.DATA_WIDTH(DATA_WIDTH)) u_merge (
		.clk(clk), .arst_n(arst_n), .en(merge_en && doe_y && doe_z),
		.ex(ex), .ey(ey), .ez(ez), .dx(dx), .dy(dy), .dz(dz),
		.hyst_x(hx_q), .hyst_y(hy_q), .hyst_z(hz_q),
		.roll(roll), .pitch(pitch), .gaz(gaz), .roll_clipped(roll_clipped),
		.pitch_clipped(pitch_clipped), .hold_xy_out(hold_xy_out), .hold_z_out(hold_z_out));
endmodule

/* rtl/core/tapid_checker.sv */
module tapid_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [13:0] roll,
	input logic signed [13:0] pitch,
	input logic               roll_clipped,
	input logic               hold_xy_out
);
	// A stalled result holds: out_valid stays and roll is stable
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(roll))
		else $error("result changed under stall");
	// No new transaction while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken with result pending");
	// Held roll and pitch axes drive zero without roll clip
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hold_xy_out |-> roll == 14'sd0 && pitch == 14'sd0 && !roll_clipped)
		else $error("held axis not zero");
	// Accepted transaction does not show a result next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result too early");
endmodule

bind three_axis_pid_with_deadband tapid_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .roll(roll), .pitch(pitch),
	.roll_clipped(roll_clipped), .hold_xy_out(hold_xy_out));
